/* hdl/median_filter_3x3_defines.svh */
// Assertion macros for the checker file of the median filter.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef MEDIAN_FILTER_3X3_DEFINES_SVH
`define MEDIAN_FILTER_3X3_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MF3_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MF3_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/mf3_pkg.sv */
package mf3_pkg;

    localparam int PIX_W        = 16;
    localparam int COORD_W      = 9;
    localparam int CFG_W        = 10;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;
    localparam int IN_TDATA_W   = 16;
    localparam int OUT_FIELDS_W = PIX_W + 2 * COORD_W;
    localparam int OUT_TDATA_W  = 40;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;
    localparam int MIN_SIZE     = 3;

    // Result queue: deep enough for the pipeline's worth of double results.
    localparam int QDEPTH = 16;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    localparam logic [CFG_W-1:0] SIZE_RESET = 10'd512;

    // Register index as decoded from the word address.
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    typedef logic signed [PIX_W-1:0] pix_t;

    typedef struct packed {
        logic                 last;
        logic [COORD_W-1:0]   row;
        logic [COORD_W-1:0]   col;
        logic [PIX_W-1:0]     value;
    } result_t;

    function automatic pix_t min2(input pix_t a, input pix_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic pix_t max2(input pix_t a, input pix_t b);
        return (a < b) ? b : a;
    endfunction

    function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

endpackage

/* hdl/median_filter_3x3.sv */
// 3x3 median filter over a raster stream of signed 16-bit pixels. One pixel is
// taken per clock as long as the 16-entry result queue has room for everything
// still in flight; a free queue never holds off the input. An interior pixel
// leaves as the median of its original 3x3 neighborhood once the pixel one row
// and one column after it completes the window, through the line-buffer,
// window and sorted-column stages. Border pixels leave unchanged at the same
// depth. One input can cause two results (a median and a border pixel), which
// enter the queue together, so the sustained rate is one pixel per clock on
// average while m_tready stays high and is set by the single output port
// draining the queue. Each result carries its column and row; tlast marks the
// last result caused by one input pixel. The line buffers need no clearing
// pass after reset. Image width and height are written through the APB port at
// byte addresses 0 and 4 and are clamped to 3..MAX_WIDTH and 3..MAX_HEIGHT.
module median_filter_3x3
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // Configuration port
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready,
    // Pixel input
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [IN_TDATA_W-1:0]   s_tdata,   // [15:0] pixel_value
    // Result output
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OUT_TDATA_W-1:0]  m_tdata,   // [15:0] out_value, [24:16] out_column,
                                               // [33:25] out_row, [39:34] zero
    output logic                    m_tlast    // last_in_run
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int BIGW = (CW > RW) ? CW : RW;
    localparam int CMPW = ((BIGW > CFG_W) ? BIGW : CFG_W) + 1;
    localparam int PEND_W = QCNT_W + 1;

    // Configuration
    logic [CFG_W-1:0]  width_cfg_reg;
    logic [CFG_W-1:0]  height_cfg_reg;
    logic              cfg_write;
    logic [CMPW-1:0]   cfg_w_ext;
    logic [CMPW-1:0]   cfg_h_ext;
    logic [CMPW-1:0]   eff_w;
    logic [CMPW-1:0]   eff_h;

    // Position counters and accept stage
    logic [CW-1:0]     col_reg;
    logic [CW-1:0]     col_next;
    logic [RW-1:0]     row_reg;
    logic [RW-1:0]     row_next;
    logic              accept;
    logic [CMPW-1:0]   c_ext;
    logic [CMPW-1:0]   r_ext;
    logic [CMPW-1:0]   c_inc;
    logic [CMPW-1:0]   r_inc;
    logic              take_med;
    logic              take_pass;

    // Line buffers
    logic [PIX_W-1:0]  upper_mem  [MAX_WIDTH];
    logic [PIX_W-1:0]  middle_mem [MAX_WIDTH];

    // Stage 1: line buffer read data
    logic              s1_valid_reg;
    logic              s1_med_reg;
    logic              s1_pass_reg;
    logic [PIX_W-1:0]  s1_pix_reg;
    logic [COORD_W-1:0] s1_col_reg;
    logic [COORD_W-1:0] s1_row_reg;
    logic [CW-1:0]     s1_idx_reg;
    logic [PIX_W-1:0]  upper_rd_reg;
    logic [PIX_W-1:0]  middle_rd_reg;

    // Stage 2: window
    logic              s2_valid_reg;
    logic              s2_med_reg;
    logic              s2_pass_reg;
    logic [PIX_W-1:0]  s2_pix_reg;
    logic [COORD_W-1:0] s2_col_reg;
    logic [COORD_W-1:0] s2_row_reg;
    pix_t              window_reg [9];
    pix_t              sorted_next [9];

    // Stage 3: columns sorted
    logic              s3_valid_reg;
    logic              s3_med_reg;
    logic              s3_pass_reg;
    logic [PIX_W-1:0]  s3_pix_reg;
    logic [COORD_W-1:0] s3_col_reg;
    logic [COORD_W-1:0] s3_row_reg;
    pix_t              sorted_reg [9];
    pix_t              lo_val;
    pix_t              mid_val;
    pix_t              hi_val;
    pix_t              median_val;
    result_t           med_entry;
    result_t           pass_entry;

    // Result queue
    result_t           queue_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QPTR_W-1:0] pass_ptr;
    logic [1:0]        push_n;
    logic              pop;
    logic [PEND_W-1:0] pending;
    result_t           head;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= SIZE_RESET;
            height_cfg_reg <= SIZE_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_IMAGE_WIDTH:  width_cfg_reg  <= pwdata[CFG_W-1:0];
                REG_IMAGE_HEIGHT: height_cfg_reg <= pwdata[CFG_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_IMAGE_WIDTH:  prdata = {{(APB_DATA_W-CFG_W){1'b0}}, width_cfg_reg};
            REG_IMAGE_HEIGHT: prdata = {{(APB_DATA_W-CFG_W){1'b0}}, height_cfg_reg};
            default:          prdata = '0;
        endcase
    end

    assign cfg_w_ext = CMPW'(width_cfg_reg);
    assign cfg_h_ext = CMPW'(height_cfg_reg);
    assign eff_w = (cfg_w_ext < CMPW'(MIN_SIZE))  ? CMPW'(MIN_SIZE)  :
                   (cfg_w_ext > CMPW'(MAX_WIDTH)) ? CMPW'(MAX_WIDTH) : cfg_w_ext;
    assign eff_h = (cfg_h_ext < CMPW'(MIN_SIZE))   ? CMPW'(MIN_SIZE)   :
                   (cfg_h_ext > CMPW'(MAX_HEIGHT)) ? CMPW'(MAX_HEIGHT) : cfg_h_ext;

    // ------------------------------------------------------------------
    // Accept stage: classify the pixel and advance the raster position
    // ------------------------------------------------------------------
    assign accept = s_tvalid & s_tready;
    assign c_ext  = CMPW'(col_reg);
    assign r_ext  = CMPW'(row_reg);
    assign c_inc  = c_ext + CMPW'(1);
    assign r_inc  = r_ext + CMPW'(1);

    // A median is ready once the pixel below and right of its center arrives.
    assign take_med  = (r_ext >= CMPW'(2)) && (r_inc <= eff_h) &&
                       (c_ext >= CMPW'(2)) && (c_inc <= eff_w);
    assign take_pass = (r_ext == '0) || (r_inc >= eff_h) ||
                       (c_ext == '0) || (c_inc >= eff_w);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (c_inc >= eff_w)
            begin
                col_next = '0;
                row_next = (r_inc >= eff_h) ? '0 : r_inc[RW-1:0];
            end
            else
            begin
                col_next = c_inc[CW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Line buffers: read on accept, written back in the cycle after. The same
    // column comes round again at the earliest with the third pixel after it.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            upper_rd_reg  <= upper_mem[col_reg];
            middle_rd_reg <= middle_mem[col_reg];
        end
        if (s1_valid_reg)
        begin
            upper_mem[s1_idx_reg]  <= middle_rd_reg;
            middle_mem[s1_idx_reg] <= s1_pix_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_med_reg  <= take_med;
            s1_pass_reg <= take_pass;
            s1_pix_reg  <= s_tdata;
            s1_col_reg  <= c_ext[COORD_W-1:0];
            s1_row_reg  <= r_ext[COORD_W-1:0];
            s1_idx_reg  <= col_reg;
        end
        s2_med_reg  <= s1_med_reg;
        s2_pass_reg <= s1_pass_reg;
        s2_pix_reg  <= s1_pix_reg;
        s2_col_reg  <= s1_col_reg;
        s2_row_reg  <= s1_row_reg;
        s3_med_reg  <= s2_med_reg;
        s3_pass_reg <= s2_pass_reg;
        s3_pix_reg  <= s2_pix_reg;
        s3_col_reg  <= s2_col_reg;
        s3_row_reg  <= s2_row_reg;
        sorted_reg  <= sorted_next;
    end

    // ------------------------------------------------------------------
    // Window: the newest column enters at the top three entries.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else if (s1_valid_reg)
        begin
            for (int i = 0; i < 6; i++)
            begin
                window_reg[i] <= window_reg[i+3];
            end
            window_reg[6] <= $signed(upper_rd_reg);
            window_reg[7] <= $signed(middle_rd_reg);
            window_reg[8] <= $signed(s1_pix_reg);
        end
    end

    // Sort each window column into min, mid, max.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sorted_next[3*k]   = min2(min2(window_reg[3*k], window_reg[3*k+1]),
                                      window_reg[3*k+2]);
            sorted_next[3*k+1] = med3(window_reg[3*k], window_reg[3*k+1],
                                      window_reg[3*k+2]);
            sorted_next[3*k+2] = max2(max2(window_reg[3*k], window_reg[3*k+1]),
                                      window_reg[3*k+2]);
        end
    end

    // With sorted columns, the median of nine is the median of the largest
    // minimum, the middle of the middles and the smallest maximum.
    assign lo_val     = max2(max2(sorted_reg[0], sorted_reg[3]), sorted_reg[6]);
    assign mid_val    = med3(sorted_reg[1], sorted_reg[4], sorted_reg[7]);
    assign hi_val     = min2(min2(sorted_reg[2], sorted_reg[5]), sorted_reg[8]);
    assign median_val = med3(lo_val, mid_val, hi_val);

    always_comb
    begin
        med_entry.value  = median_val;
        med_entry.col    = s3_col_reg - COORD_W'(1);
        med_entry.row    = s3_row_reg - COORD_W'(1);
        med_entry.last   = ~s3_pass_reg;
        pass_entry.value = s3_pix_reg;
        pass_entry.col   = s3_col_reg;
        pass_entry.row   = s3_row_reg;
        pass_entry.last  = 1'b1;
    end

    // ------------------------------------------------------------------
    // Result queue. The input is held off unless the queue can take two
    // results for every pixel in flight plus the one being accepted.
    // ------------------------------------------------------------------
    assign push_n   = s3_valid_reg ? ({1'b0, s3_med_reg} + {1'b0, s3_pass_reg}) : 2'd0;
    assign pass_ptr = wr_ptr_reg + QPTR_W'(s3_med_reg);
    assign pop      = m_tvalid & m_tready;

    always_ff @(posedge clk)
    begin
        if (s3_valid_reg && s3_med_reg)
        begin
            queue_reg[wr_ptr_reg] <= med_entry;
        end
        if (s3_valid_reg && s3_pass_reg)
        begin
            queue_reg[pass_ptr] <= pass_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + QPTR_W'(push_n);
            rd_ptr_reg <= rd_ptr_reg + QPTR_W'(pop);
            count_reg  <= count_reg + QCNT_W'(push_n) - QCNT_W'(pop);
        end
    end

    assign pending = PEND_W'(count_reg) + PEND_W'({s1_valid_reg, 1'b0})
                   + PEND_W'({s2_valid_reg, 1'b0}) + PEND_W'({s3_valid_reg, 1'b0});
    assign s_tready = (pending + PEND_W'(2)) <= PEND_W'(QDEPTH);

    assign head     = queue_reg[rd_ptr_reg];
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, head.row, head.col, head.value};
    assign m_tlast  = head.last;

endmodule

/* hdl/mf3_checker.sv */
`include "median_filter_3x3_defines.svh"

module mf3_checker
    import mf3_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    psel,
    input logic                    penable,
    input logic                    pwrite,
    input logic [APB_ADDR_W-1:0]   paddr,
    input logic [APB_DATA_W-1:0]   pwdata,
    input logic [APB_DATA_W-1:0]   prdata,
    input logic                    pready,
    input logic                    s_tready,
    input logic                    m_tvalid,
    input logic                    m_tready,
    input logic [OUT_TDATA_W-1:0]  m_tdata,
    input logic                    m_tlast
);

    // A stalled result must not change under the consumer.
    `MF3_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")

    // With the queue empty, the credit check must leave the input open.
    `MF3_ASSERT_NOW(a_empty_ready, !m_tvalid, s_tready, "input held off with empty result queue")

    // Both results of one pixel enter the queue together, so the second is there.
    `MF3_ASSERT_NEXT(a_pair_whole, m_tvalid && m_tready && !m_tlast, m_tvalid, "second result of a pair missing")

    // A read right after a write to the same register returns the written value.
    `MF3_ASSERT_NOW(a_readback, psel && penable && !pwrite && $past(psel && penable && pwrite && pready) && (paddr[2] == $past(paddr[2])), prdata[CFG_W-1:0] == $past(pwdata[CFG_W-1:0]), "register readback mismatch")

endmodule

bind median_filter_3x3 mf3_checker u_mf3_checker (.*);

/* tb/sv/median_filter_3x3_tb.sv */
module median_filter_3x3_tb;
    import mf3_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIM      = 512;
    localparam int SETTLE       = 12;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 2000;
    localparam int PHASE_PIXELS = 24;
    localparam int WIDE_PIXELS  = 20;

    typedef struct {
        pix_t               value;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               last;
    } pixel_out_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;    // [15:0] pixel_value
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;         // [15:0] out_value, [24:16] out_column,
                                             // [33:25] out_row, [39:34] zero
    logic                   m_tlast;         // last_in_run

    // Shadow of the filter state.
    pix_t               upper_row [MAX_DIM];
    pix_t               middle_row [MAX_DIM];
    pix_t               win [9];
    int                 col_cnt;
    int                 row_cnt;
    logic [CFG_W-1:0]   width_reg = SIZE_RESET;
    logic [CFG_W-1:0]   height_reg = SIZE_RESET;

    pixel_out_t         pending_pixels [$];
    pixel_out_t         want_px;
    int                 errors = 0;

    int                 tx_idle_pct = 0;
    int                 rx_stall_pct = 0;
    logic               hold_req = 1'b0;
    logic               hold_ack = 1'b0;
    int                 hold_left = 0;

    median_filter_3x3 DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int eff_size(input logic [CFG_W-1:0] v);
        if (v < MIN_SIZE)
            return MIN_SIZE;
        if (v > MAX_DIM)
            return MAX_DIM;
        return int'(v);
    endfunction

    // The median is the value whose rank range covers the fifth position.
    function automatic pix_t median9(input pix_t v [9]);
        int lt;
        int eq;
        for (int i = 0; i < 9; i++)
        begin
            lt = 0;
            eq = 0;
            for (int j = 0; j < 9; j++)
            begin
                if (v[j] < v[i])
                    lt++;
                else if (v[j] == v[i])
                    eq++;
            end
            if (lt <= 4 && lt + eq > 4)
                return v[i];
        end
        return v[0];
    endfunction

    task automatic filter_pixel(input pix_t px);
        int w;
        int h;
        int c;
        int r;
        int idx;
        int n;
        pixel_out_t res [2];
        w = eff_size(width_reg);
        h = eff_size(height_reg);
        c = col_cnt;
        r = row_cnt;
        idx = c % MAX_DIM;
        n = 0;
        for (int i = 0; i < 6; i++)
            win[i] = win[i + 3];
        win[6] = upper_row[idx];
        win[7] = middle_row[idx];
        win[8] = px;
        upper_row[idx] = middle_row[idx];
        middle_row[idx] = px;
        if (r >= 2 && r + 1 <= h && c >= 2 && c + 1 <= w)
        begin
            res[n].value = median9(win);
            res[n].col = COORD_W'(c - 1);
            res[n].row = COORD_W'(r - 1);
            res[n].last = 1'b0;
            n++;
        end
        if (r == 0 || r + 1 >= h || c == 0 || c + 1 >= w)
        begin
            res[n].value = px;
            res[n].col = COORD_W'(c);
            res[n].row = COORD_W'(r);
            res[n].last = 1'b0;
            n++;
        end
        if (n > 0)
            res[n - 1].last = 1'b1;
        for (int i = 0; i < n; i++)
            pending_pixels.push_back(res[i]);
        if (c + 1 >= w)
        begin
            col_cnt = 0;
            row_cnt = (r + 1 >= h) ? 0 : r + 1;
        end
        else
        begin
            col_cnt = c + 1;
        end
    endtask

    // Mostly full-range values, with many near-equal values to make ties.
    function automatic pix_t rand_pixel();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60)
            return pix_t'($urandom());
        if (pick < 85)
            return pix_t'($signed($urandom_range(6)) - 3);
        return ($urandom_range(1) != 0) ? 16'sh7FFF : -16'sh8000;
    endfunction

    // Without big_ok the size stays within the columns that earlier tests have
    // visited at least twice, so every median reads line entries already written.
    function automatic logic [CFG_W-1:0] pick_size(input int common_hi, input bit big_ok);
        int pick;
        pick = $urandom_range(99);
        if (pick < 70 || (pick >= 80 && !big_ok))
            return CFG_W'($urandom_range(common_hi, MIN_SIZE));
        if (pick < 80)
            return CFG_W'($urandom_range(MIN_SIZE - 1, 0));
        if (pick < 90)
            return CFG_W'($urandom_range(1023, MAX_DIM + 1));
        return CFG_W'(MAX_DIM);
    endfunction

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= ($urandom() & ~32'h3FF) | APB_DATA_W'(val);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_IMAGE_WIDTH)
            width_reg = val;
        else
            height_reg = val;
    endtask

    task automatic set_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
    endtask

    task automatic send_pixel(input pix_t px);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= px;
        do
            @(posedge clk);
        while (!s_tready);
        filter_pixel(px);
    endtask

    // Stops offering pixels and waits until every expected result is out.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_traffic(input int tx_pct, input int rx_pct);
        tx_idle_pct <= tx_pct;
        rx_stall_pct <= rx_pct;
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_pixels.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: value %0d col %0d row %0d last %0b",
                         $time, $signed(m_tdata[PIX_W-1:0]), m_tdata[PIX_W +: COORD_W],
                         m_tdata[PIX_W + COORD_W +: COORD_W], m_tlast);
            end
            else
            begin
                want_px = pending_pixels.pop_front();
                if (m_tdata[PIX_W-1:0] !== want_px.value
                    || m_tdata[PIX_W +: COORD_W] !== want_px.col
                    || m_tdata[PIX_W + COORD_W +: COORD_W] !== want_px.row
                    || m_tlast !== want_px.last)
                begin
                    errors++;
                    $display({"%0t: mismatch: expected value %0d col %0d row %0d last %0b,",
                              " got value %0d col %0d row %0d last %0b"},
                             $time, want_px.value, want_px.col, want_px.row, want_px.last,
                             $signed(m_tdata[PIX_W-1:0]), m_tdata[PIX_W +: COORD_W],
                             m_tdata[PIX_W + COORD_W +: COORD_W], m_tlast);
                end
            end
        end
    end

    // Ends the run if nothing moves on either stream for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Three-by-three slices: one median each, with the signed extremes and
    // sizes below the minimum.
    task automatic test_small_slices();
        pix_t first [9];
        set_size(10'd0, 10'd2);
        first = '{16'sh7FFF, -16'sh8000, 16'sh0000, -16'sh0001, 16'sh0001,
                  16'sh5555, -16'sh5556, 16'sh0064, -16'sh0064};
        foreach (first[i])
            send_pixel(first[i]);
        for (int i = 0; i < 9; i++)
            send_pixel((i % 2 == 0) ? -16'sh8000 : 16'sh7FFF);
        drain();
    endtask

    // A width above the maximum acts as the maximum; the short run stays in the
    // first row and gives columns 3 to 19 their first visit.
    task automatic test_widest_rows();
        set_size(10'd1023, 10'd3);
        for (int i = 0; i < WIDE_PIXELS; i++)
            send_pixel(rand_pixel());
        drain();
    endtask

    task automatic test_resize_midslice();
        set_size(10'd10, 10'd8);
        for (int i = 0; i < 27; i++)
            send_pixel(rand_pixel());
        drain();
        // The column counter now lies past the new last column.
        write_reg(REG_IMAGE_WIDTH, 10'd5);
        for (int i = 0; i < 12; i++)
            send_pixel(rand_pixel());
        drain();
        // The row counter now lies past the new last row.
        write_reg(REG_IMAGE_HEIGHT, 10'd4);
        for (int i = 0; i < 13; i++)
            send_pixel(rand_pixel());
        drain();
        write_reg(REG_IMAGE_WIDTH, 10'd9);
        for (int i = 0; i < 40; i++)
            send_pixel(rand_pixel());
        drain();
    endtask

    task automatic test_random_traffic();
        int tx_modes [4];
        int rx_modes [4];
        tx_modes = '{0, 49, 0, 19};
        rx_modes = '{0, 0, 49, 19};
        for (int m = 0; m < 4; m++)
        begin
            set_traffic(tx_modes[m], rx_modes[m]);
            for (int k = 0; k < 2; k++)
            begin
                set_size(pick_size(10, 1'b0), pick_size(10, 1'b1));
                for (int i = 0; i < PHASE_PIXELS; i++)
                    send_pixel(rand_pixel());
                drain();
            end
        end
        set_traffic(0, 0);
    endtask

    // The output holds off long enough for the result queue to fill and the
    // input to stall; afterwards the sender waits for everything to drain.
    task automatic test_output_backpressure();
        set_size(10'd6, 10'd5);
        hold_req <= ~hold_req;
        for (int i = 0; i < 80; i++)
            send_pixel(rand_pixel());
        drain();
        for (int i = 0; i < 20; i++)
            send_pixel(rand_pixel());
        drain();
    endtask

    initial
    begin
        foreach (upper_row[i])
        begin
            upper_row[i] = '0;
            middle_row[i] = '0;
        end
        foreach (win[i])
            win[i] = '0;
        col_cnt = 0;
        row_cnt = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_small_slices();
        test_widest_rows();
        test_resize_midslice();
        test_random_traffic();
        test_output_backpressure();
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (pending_pixels.size() != 0)
            errors++;
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
